// ----- rtl/core/kdr_pkg.sv -----
// kdr_pkg: shared types and constants for the key debounce / auto-repeat unit
// no dependencies; imported by every rtl/core module of the block
`timescale 1ns / 1ps

package kdr_pkg;

  // fixed field widths
  localparam int KEY_BITS   = 8;
  localparam int KEY_IDX_W  = 3;
  localparam int CODE_W     = 5;
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 2;
  localparam int DATA_W     = 16;
  localparam int FILT_W     = 3;
  localparam int HOLD_W     = 16;
  localparam int RPT_W      = 8;

  // request modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_LONG_PRESS  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_RPT_PERIOD  = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LONG_MASK   = 2'd2;
  localparam logic [ADDR_W-1:0] REG_RPT_MASK    = 2'd3;

  // register reset values
  localparam logic [HOLD_W-1:0]   LONG_PRESS_RST = 16'd150;
  localparam logic [RPT_W-1:0]    RPT_PERIOD_RST = 8'd1;
  localparam logic [KEY_BITS-1:0] LONG_MASK_RST  = 8'd207;
  localparam logic [KEY_BITS-1:0] RPT_MASK_RST   = 8'd207;

  // bit v set when v mod 3 == 2 (release codes), for 5-bit codes
  localparam logic [31:0] MOD3_TWO_MASK = 32'h2492_4924;

  typedef struct packed {
    logic [HOLD_W-1:0]   long_press_ticks;
    logic [RPT_W-1:0]    repeat_period;
    logic [KEY_BITS-1:0] long_enable_mask;
    logic [KEY_BITS-1:0] repeat_enable_mask;
  } kdr_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch_pins;
    logic visit;
    logic pop;
    logic clear;
    logic out_load;
  } kdr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } kdr_sts_t;

  // press code of key k: 3*k+1
  function automatic logic [CODE_W-1:0] press_code(input logic [KEY_IDX_W-1:0] k);
    logic [CODE_W-1:0] kk;
    kk = CODE_W'(k);
    return (kk << 1) + kk + CODE_W'(1);
  endfunction

endpackage

// ----- rtl/core/kdr_channels.sv -----
// kdr_channels: valid/ready channel interfaces of the key unit
// depends on kdr_pkg for field widths
`timescale 1ns / 1ps

interface kdr_req_if import kdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [KEY_BITS-1:0] key_pins;

  modport source (output valid, mode, key_pins, input ready);
  modport sink   (input valid, mode, key_pins, output ready);
endinterface

interface kdr_rsp_if import kdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   key_code;
  logic                key_valid;
  logic [KEY_BITS-1:0] key_states;

  modport source (output valid, key_code, key_valid, key_states, input ready);
  modport sink   (input valid, key_code, key_valid, key_states, output ready);
endinterface

interface kdr_cfg_if import kdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/kdr_regs.sv -----
// kdr_regs: configuration register file of the key unit
// depends on kdr_pkg and the kdr_cfg_if channel
`timescale 1ns / 1ps

module kdr_regs import kdr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  kdr_cfg_if.sink        cfg,
  output kdr_cfg_t       regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.long_press_ticks   <= LONG_PRESS_RST;
      regs.repeat_period      <= RPT_PERIOD_RST;
      regs.long_enable_mask   <= LONG_MASK_RST;
      regs.repeat_enable_mask <= RPT_MASK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_LONG_PRESS: regs.long_press_ticks   <= cfg.data;
        REG_RPT_PERIOD: regs.repeat_period      <= cfg.data[RPT_W-1:0];
        REG_LONG_MASK:  regs.long_enable_mask   <= cfg.data[KEY_BITS-1:0];
        REG_RPT_MASK:   regs.repeat_enable_mask <= cfg.data[KEY_BITS-1:0];
      endcase
    end
  end

endmodule

// ----- rtl/core/kdr_ctrl.sv -----
// kdr_ctrl: sequencer of the key unit, one key visited per cycle on a scan tick
// depends on kdr_pkg and the kdr_req_if channel
`timescale 1ns / 1ps

module kdr_ctrl import kdr_pkg::*; #(
  parameter int NUM_KEYS = 8,
  parameter int KW       = 3
) (
  input  logic          clk,
  input  logic          rst,
  kdr_req_if.sink       req,
  input  kdr_sts_t      sts,
  output kdr_cmd_t      cmd,
  output logic [KW-1:0] key_idx
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

  state_t state;
  logic   accept;

  // request side handshake
  assign req.ready = (state == ST_IDLE) && sts.out_free;
  assign accept    = req.valid && req.ready;

  // commands to the datapath
  always_comb begin
    cmd.latch_pins = accept && (req.mode == MODE_TICK);
    cmd.visit      = (state == ST_SCAN);
    cmd.pop        = accept && (req.mode == MODE_POP);
    cmd.clear      = accept && (req.mode == MODE_CLEAR);
    cmd.out_load   = (accept && (req.mode != MODE_TICK)) ||
                     ((state == ST_FINISH) && sts.out_free);
  end

  // state and key counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      key_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.latch_pins) begin
            state   <= ST_SCAN;
            key_idx <= '0;
          end
        end
        ST_SCAN: begin
          if (key_idx == LAST_KEY) begin
            state <= ST_FINISH;
          end else begin
            key_idx <= key_idx + KW'(1);
          end
        end
        ST_FINISH: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/kdr_datapath.sv -----
// kdr_datapath: per-key filter/hold/repeat state, key-code fifo and result register
// depends on kdr_pkg and the kdr_rsp_if channel; driven by kdr_ctrl commands
`timescale 1ns / 1ps

module kdr_datapath import kdr_pkg::*; #(
  parameter int NUM_KEYS     = 8,
  parameter int FIFO_DEPTH   = 4,
  parameter int FILTER_TICKS = 3,
  parameter int KW           = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  kdr_cmd_t            cmd,
  input  logic [KW-1:0]       key_idx,
  input  logic [KEY_BITS-1:0] key_pins,
  input  kdr_cfg_t            regs,
  output kdr_sts_t            sts,
  kdr_rsp_if.source           rsp
);

  localparam int FW = $clog2(FIFO_DEPTH);
  localparam logic [FILT_W-1:0] FT     = FILT_W'(FILTER_TICKS);
  localparam logic [FILT_W-1:0] FT2    = FILT_W'(2 * FILTER_TICKS);
  localparam logic [FW-1:0]     LAST_W = FW'(FIFO_DEPTH - 1);

  // per-key state
  logic [FILT_W-1:0] filt   [NUM_KEYS];
  logic              pressed[NUM_KEYS];
  logic [HOLD_W-1:0] hold   [NUM_KEYS];
  logic [RPT_W-1:0]  rpt    [NUM_KEYS];

  // code fifo, contents undefined until written
  logic [CODE_W-1:0] fifo_mem[FIFO_DEPTH];
  logic [FW-1:0]     wr_ptr;
  logic [FW-1:0]     rd_ptr;

  logic [KEY_BITS-1:0] pins;
  logic                out_valid;

  logic [KEY_IDX_W-1:0] idx3;
  logic                 down;
  logic                 lp_on;
  logic                 rp_on;
  logic [FILT_W-1:0]    cur_filt;
  logic [HOLD_W-1:0]    cur_hold;
  logic [RPT_W-1:0]     rpt_inc;
  logic [FILT_W-1:0]    filt_next;
  logic                 pressed_next;
  logic [HOLD_W-1:0]    hold_next;
  logic [RPT_W-1:0]     rpt_next;
  logic                 push;

  logic                 fifo_empty;
  logic [CODE_W-1:0]    pop_data;
  logic                 pop_ok;
  logic                 code_good;
  logic [KEY_BITS-1:0]  states_vec;

  assign idx3     = KEY_IDX_W'(key_idx);
  assign down     = ~pins[idx3];
  assign lp_on    = (regs.long_press_ticks != '0) && regs.long_enable_mask[idx3];
  assign rp_on    = (regs.repeat_period != '0) && regs.repeat_enable_mask[idx3];
  assign cur_filt = filt[key_idx];
  assign cur_hold = hold[key_idx];
  assign rpt_inc  = rpt[key_idx] + RPT_W'(1);

  // key visit: debounce, press detect, long press and repeat
  always_comb begin
    filt_next    = cur_filt;
    pressed_next = pressed[key_idx];
    hold_next    = cur_hold;
    rpt_next     = rpt[key_idx];
    push         = 1'b0;
    if (down) begin
      if (cur_filt < FT) begin
        filt_next = FT;
      end else if (cur_filt < FT2) begin
        filt_next = cur_filt + FILT_W'(1);
      end else begin
        if (!pressed[key_idx]) begin
          pressed_next = 1'b1;
          push         = 1'b1;
        end
        if (lp_on) begin
          if (cur_hold < regs.long_press_ticks) begin
            hold_next = cur_hold + HOLD_W'(1);
          end else if (rp_on) begin
            if (rpt_inc >= regs.repeat_period) begin
              rpt_next = '0;
              push     = 1'b1;
            end else begin
              rpt_next = rpt_inc;
            end
          end
        end
      end
    end else begin
      if (cur_filt > FT) begin
        filt_next = cur_filt - FILT_W'(1);
      end else if (cur_filt != '0) begin
        filt_next = '0;
      end else begin
        pressed_next = 1'b0;
      end
      hold_next = '0;
      rpt_next  = '0;
    end
  end

  // pop path; release codes and zero entries are consumed silently
  assign fifo_empty = (rd_ptr == wr_ptr);
  assign pop_data   = fifo_mem[rd_ptr];
  assign pop_ok     = cmd.pop && !fifo_empty;
  assign code_good  = (pop_data != '0) && !MOD3_TWO_MASK[pop_data];

  // debounced flags as a bit vector
  always_comb begin
    states_vec = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      states_vec[k] = pressed[k];
    end
  end

  assign sts.out_free = !out_valid || rsp.ready;

  // latched pin levels for the scan
  always_ff @(posedge clk) begin
    if (cmd.latch_pins) begin
      pins <= key_pins;
    end
  end

  // per-key state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        filt[k]    <= '0;
        pressed[k] <= 1'b0;
        hold[k]    <= '0;
        rpt[k]     <= '0;
      end
    end else if (cmd.visit) begin
      filt[key_idx]    <= filt_next;
      pressed[key_idx] <= pressed_next;
      hold[key_idx]    <= hold_next;
      rpt[key_idx]     <= rpt_next;
    end
  end

  // fifo storage, written without overflow check
  always_ff @(posedge clk) begin
    if (cmd.visit && push) begin
      fifo_mem[wr_ptr] <= press_code(idx3);
    end
  end

  // fifo pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (cmd.visit && push) begin
        wr_ptr <= (wr_ptr == LAST_W) ? '0 : wr_ptr + FW'(1);
      end
      if (cmd.clear) begin
        rd_ptr <= wr_ptr;
      end else if (pop_ok) begin
        rd_ptr <= (rd_ptr == LAST_W) ? '0 : rd_ptr + FW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.key_code   <= (pop_ok && code_good) ? pop_data : '0;
      rsp.key_valid  <= pop_ok && code_good;
      rsp.key_states <= states_vec;
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ----- rtl/core/key_debounce_repeat_fifo_unit.sv -----
// key_debounce_repeat_fifo_unit: eight-key debouncer with auto-repeat and code fifo
// depends on kdr_pkg, kdr_channels, kdr_regs, kdr_ctrl and kdr_datapath
// scan tick: keys visited in turn by the shared key datapath, one key per cycle, then
//   the result is loaded; pop, clear and mode 3 load the result register at acceptance
// throughput: no request during a scan; one pop or clear per cycle while rsp.ready
// reset: synchronous rst zeroes key state and fifo pointers, loads register defaults;
//   fifo entries stay undefined until written, no clearing pass
`timescale 1ns / 1ps

module key_debounce_repeat_fifo_unit import kdr_pkg::*; #(
  parameter int NUM_KEYS     = 8,
  parameter int FIFO_DEPTH   = 4,
  parameter int FILTER_TICKS = 3
) (
  input  logic      clk,
  input  logic      rst,
  kdr_req_if.sink   req,
  kdr_rsp_if.source rsp,
  kdr_cfg_if.sink   cfg
);

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  kdr_cfg_t      regs;
  kdr_cmd_t      cmd;
  kdr_sts_t      sts;
  logic [KW-1:0] key_idx;

  // configuration registers
  kdr_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // sequencer
  kdr_ctrl #(
    .NUM_KEYS (NUM_KEYS),
    .KW       (KW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .sts     (sts),
    .cmd     (cmd),
    .key_idx (key_idx)
  );

  // key state, fifo and result register
  kdr_datapath #(
    .NUM_KEYS     (NUM_KEYS),
    .FIFO_DEPTH   (FIFO_DEPTH),
    .FILTER_TICKS (FILTER_TICKS),
    .KW           (KW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .key_idx  (key_idx),
    .key_pins (req.key_pins),
    .regs     (regs),
    .sts      (sts),
    .rsp      (rsp)
  );

endmodule

// ----- rtl/core/kdr_checker.sv -----
// kdr_checker: port-level assertions for key_debounce_repeat_fifo_unit
// depends on kdr_pkg; attached to the top level by the bind at the end
`timescale 1ns / 1ps

module kdr_checker import kdr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [CODE_W-1:0]   key_code,
  input logic                key_valid,
  input logic [KEY_BITS-1:0] key_states
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_code) &&
      $stable(key_valid) && $stable(key_states))
    else $error("stalled result changed");

  // no request taken while a result would be overwritten
  assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid || rsp_ready)
    else $error("request ready while result register full");

  // a valid code is a press code 3*k+1
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && key_valid |-> key_code == 5'd1 || key_code == 5'd4 ||
      key_code == 5'd7 || key_code == 5'd10 || key_code == 5'd13 ||
      key_code == 5'd16 || key_code == 5'd19 || key_code == 5'd22)
    else $error("valid key code is not a press code");

  // no code without its valid flag
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !key_valid |-> key_code == '0)
    else $error("key code nonzero without key_valid");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind key_debounce_repeat_fifo_unit kdr_checker u_kdr_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .key_code   (rsp.key_code),
  .key_valid  (rsp.key_valid),
  .key_states (rsp.key_states)
);

// ----- bench/tb_key_debounce_repeat_fifo_unit.sv -----
// tb_key_debounce_repeat_fifo_unit: self-checking bench for the key debounce / auto-repeat unit
// sends scan ticks, pops and clears, and checks each response against a typed answer or a behavioral key model
// depends on kdr_pkg, kdr_channels and key_debounce_repeat_fifo_unit
`timescale 1ns / 1ps

module tb_key_debounce_repeat_fifo_unit;
  import kdr_pkg::*;

  localparam int N_KEYS         = 8;
  localparam int FIFO_SLOTS     = 4;
  localparam int FILT_TICKS     = 3;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int SETTLE_CYCLES  = N_KEYS + 4;
  localparam int PHASE_ITEMS    = 80;
  localparam int N_ROWS         = 25;

  // mode 3 has no name in the package; the unit treats it as a no-op
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0]   key_code;
    logic                key_valid;
    logic [KEY_BITS-1:0] key_states;
  } key_result_t;

  typedef struct {
    bit          fixed;
    key_result_t want;
  } fixed_answer_t;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [KEY_BITS-1:0] pins;
    bit                  fixed;
    key_result_t         want;
  } stim_row_t;

  localparam key_result_t NO_KEYS  = '{key_code: '0, key_valid: 1'b0, key_states: 8'h00};
  localparam key_result_t ALL_KEYS = '{key_code: '0, key_valid: 1'b0, key_states: 8'hFF};

  logic clk = 1'b0;
  logic rst = 1'b1;

  kdr_req_if req_ch ();
  kdr_rsp_if rsp_ch ();
  kdr_cfg_if cfg_ch ();

  key_debounce_repeat_fifo_unit #(
    .NUM_KEYS     (N_KEYS),
    .FIFO_DEPTH   (FIFO_SLOTS),
    .FILTER_TICKS (FILT_TICKS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // directed table: typed answers only where obvious, the rest from the key model
  stim_row_t directed_rows [0:N_ROWS-1] = '{
    '{MODE_POP,   8'hFF, 1'b1, NO_KEYS},   // pop on an empty fifo after reset
    '{MODE_CLEAR, 8'hFF, 1'b1, NO_KEYS},
    '{MODE_NOP,   8'h00, 1'b1, NO_KEYS},   // mode 3 ignores the pins
    '{MODE_TICK,  8'hFF, 1'b1, NO_KEYS},
    '{MODE_TICK,  8'h00, 1'b1, NO_KEYS},   // all keys down, filter still settling
    '{MODE_TICK,  8'h00, 1'b1, NO_KEYS},
    '{MODE_TICK,  8'h00, 1'b1, NO_KEYS},
    '{MODE_TICK,  8'h00, 1'b1, NO_KEYS},
    '{MODE_TICK,  8'h00, 1'b1, ALL_KEYS},  // eight presses wrap the four-entry fifo
    '{MODE_POP,   8'h00, 1'b1, ALL_KEYS},  // wrapped fifo reads as empty
    '{MODE_TICK,  8'hFE, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'hFF, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'hFF, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'hFF, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'hFF, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'hFF, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'h7F, 1'b0, NO_KEYS},   // key 7 alone through the filter
    '{MODE_TICK,  8'h7F, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'h7F, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'h7F, 1'b0, NO_KEYS},
    '{MODE_TICK,  8'h7F, 1'b0, NO_KEYS},
    '{MODE_POP,   8'hFF, 1'b0, NO_KEYS},
    '{MODE_POP,   8'hFF, 1'b0, NO_KEYS},
    '{MODE_CLEAR, 8'h00, 1'b0, NO_KEYS},
    '{MODE_NOP,   8'hFF, 1'b0, NO_KEYS}
  };

  // key model state
  logic [FILT_W-1:0] filt_cnt     [N_KEYS];
  bit                debounced    [N_KEYS];
  logic [HOLD_W-1:0] held_ticks   [N_KEYS];
  logic [RPT_W-1:0]  repeat_ticks [N_KEYS];
  logic [CODE_W-1:0] code_slots   [FIFO_SLOTS];
  logic [1:0]        wr_ptr;
  logic [1:0]        rd_ptr;
  kdr_cfg_t          cfg_shadow;

  key_result_t   awaited_results [$];
  fixed_answer_t fixed_answers   [$];

  int error_count = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  bit idle_on     = 1'b1;
  bit squeeze_req = 1'b0;

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void push_code(input logic [CODE_W-1:0] c);
    code_slots[wr_ptr] = c;
    wr_ptr = wr_ptr + 2'd1;
  endfunction

  // one key visit of a scan tick
  function automatic void scan_key(input int k, input bit down);
    logic [CODE_W-1:0] c;
    logic [RPT_W-1:0]  r;
    c = CODE_W'(3 * k + 1);
    if (down) begin
      if (filt_cnt[k] < FILT_TICKS) begin
        filt_cnt[k] = FILT_W'(FILT_TICKS);
      end else if (filt_cnt[k] < 2 * FILT_TICKS) begin
        filt_cnt[k] = filt_cnt[k] + 1'b1;
      end else begin
        if (!debounced[k]) begin
          debounced[k] = 1'b1;
          push_code(c);
        end
        if (cfg_shadow.long_press_ticks != 0 && cfg_shadow.long_enable_mask[k]) begin
          if (held_ticks[k] < cfg_shadow.long_press_ticks) begin
            held_ticks[k] = held_ticks[k] + 1'b1;
          end else if (cfg_shadow.repeat_period != 0 && cfg_shadow.repeat_enable_mask[k]) begin
            r = repeat_ticks[k] + 1'b1;
            if (r >= cfg_shadow.repeat_period) begin
              r = '0;
              push_code(c);
            end
            repeat_ticks[k] = r;
          end
        end
      end
    end else begin
      if (filt_cnt[k] > FILT_TICKS)
        filt_cnt[k] = filt_cnt[k] - 1'b1;
      else if (filt_cnt[k] != 0)
        filt_cnt[k] = '0;
      else
        debounced[k] = 1'b0;
      held_ticks[k]   = '0;
      repeat_ticks[k] = '0;
    end
  endfunction

  // advance the key model by one request and return the response it implies
  function automatic key_result_t debounce_step(input logic [MODE_W-1:0] mode,
                                                input logic [KEY_BITS-1:0] pins);
    key_result_t       res;
    logic [CODE_W-1:0] v;
    res = '0;
    case (mode)
      MODE_TICK: begin
        for (int k = 0; k < N_KEYS; k++)
          scan_key(k, !pins[k]);
      end
      MODE_POP: begin
        if (rd_ptr != wr_ptr) begin
          v = code_slots[rd_ptr];
          rd_ptr = rd_ptr + 2'd1;
          if (v != 0 && v % 3 != 2) begin
            res.key_code  = v;
            res.key_valid = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        rd_ptr = wr_ptr;
      end
      default: ;
    endcase
    for (int k = 0; k < N_KEYS; k++)
      res.key_states[k] = debounced[k];
    return res;
  endfunction

  // request transaction: update the model, queue the answer
  always @(posedge clk) begin
    fixed_answer_t hint;
    key_result_t   model_out;
    if (!rst && req_ch.valid && req_ch.ready) begin
      model_out = debounce_step(req_ch.mode, req_ch.key_pins);
      hint = fixed_answers.pop_front();
      awaited_results.push_back(hint.fixed ? hint.want : model_out);
    end
  end

  // register write transaction
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.addr)
        REG_LONG_PRESS: cfg_shadow.long_press_ticks   = cfg_ch.data;
        REG_RPT_PERIOD: cfg_shadow.repeat_period      = cfg_ch.data[RPT_W-1:0];
        REG_LONG_MASK:  cfg_shadow.long_enable_mask   = cfg_ch.data[KEY_BITS-1:0];
        REG_RPT_MASK:   cfg_shadow.repeat_enable_mask = cfg_ch.data[KEY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // response transaction: compare against the oldest awaited result
  always @(posedge clk) begin
    key_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        log_mismatch($sformatf("response with nothing awaited: code %0d states %h",
                               rsp_ch.key_code, rsp_ch.key_states));
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.key_code !== want.key_code)
          log_mismatch($sformatf("key_code %0d, want %0d", rsp_ch.key_code, want.key_code));
        if (rsp_ch.key_valid !== want.key_valid)
          log_mismatch($sformatf("key_valid %b, want %b", rsp_ch.key_valid, want.key_valid));
        if (rsp_ch.key_states !== want.key_states)
          log_mismatch($sformatf("key_states %h, want %h",
                                 rsp_ch.key_states, want.key_states));
      end
    end
  end

  // response side: random stall bursts, plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_req) begin
        rsp_ch.ready <= 1'b0;
        for (int c = 0; c < SQUEEZE_CYCLES; c++) @(posedge clk);
        squeeze_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_BITS-1:0] pins,
                           input bit fixed, input key_result_t want);
    fixed_answer_t hint;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    hint.fixed = fixed;
    hint.want  = want;
    fixed_answers.push_back(hint);
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= mode;
    req_ch.key_pins <= pins;
    do @(posedge clk); while (!req_ch.ready);
    if (mode != MODE_NOP)
      items_sent++;
  endtask

  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [KEY_BITS-1:0] pins);
    send_item(mode, pins, 1'b0, NO_KEYS);
  endtask

  // let every awaited response arrive, then let the unit settle
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0 || fixed_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // 8-bit registers get random upper data bits, which the unit drops
  task automatic apply_settings(input logic [HOLD_W-1:0] long_ticks,
                                input logic [RPT_W-1:0] period,
                                input logic [KEY_BITS-1:0] long_mask,
                                input logic [KEY_BITS-1:0] rpt_mask);
    wait_idle();
    write_reg(REG_LONG_PRESS, long_ticks);
    write_reg(REG_RPT_PERIOD, {8'($urandom()), period});
    write_reg(REG_LONG_MASK, {8'($urandom()), long_mask});
    write_reg(REG_RPT_MASK, {8'($urandom()), rpt_mask});
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly clean press / hold / release sequences with pops, some noise
  task automatic run_phase(input int n_items, input int long_hold);
    int               target;
    int               hold;
    bit               first;
    logic [KEY_BITS-1:0] down;
    target = items_sent + n_items;
    first  = 1'b1;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0:       down = 8'(1 << $urandom_range(0, 7));
          1:       down = 8'(1 << $urandom_range(0, 7)) | 8'(1 << $urandom_range(0, 7));
          2:       down = 8'($urandom());
          default: down = 8'hFF;
        endcase
        if (first && long_hold > 0)
          hold = long_hold;
        else if ($urandom_range(0, 5) == 0)
          hold = $urandom_range(15, 40);
        else
          hold = $urandom_range(3, 12);
        first = 1'b0;
        for (int t = 0; t < hold; t++) begin
          // occasional bounce on a single pin
          if ($urandom_range(0, 9) == 0)
            send_op(MODE_TICK, ~down ^ 8'(1 << $urandom_range(0, 7)));
          else
            send_op(MODE_TICK, ~down);
          if ($urandom_range(0, 2) == 0)
            send_op(MODE_POP, 8'($urandom()));
        end
        if ($urandom_range(0, 15) == 0)
          send_op(MODE_CLEAR, 8'($urandom()));
        repeat ($urandom_range(1, 7)) send_op(MODE_TICK, 8'hFF);
        repeat ($urandom_range(0, 4)) send_op(MODE_POP, 8'($urandom()));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_op(MODE_TICK, 8'($urandom()));
          5, 6, 7:       send_op(MODE_POP, 8'($urandom()));
          8:             send_op(MODE_CLEAR, 8'($urandom()));
          default:       send_op(MODE_NOP, 8'($urandom()));
        endcase
      end
    end
  endtask

  initial begin
    // known input levels from time zero
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_TICK;
    req_ch.key_pins = 8'hFF;
    cfg_ch.valid    = 1'b0;
    cfg_ch.addr     = REG_LONG_PRESS;
    cfg_ch.data     = '0;

    // model after reset
    for (int k = 0; k < N_KEYS; k++) begin
      filt_cnt[k]     = '0;
      debounced[k]    = 1'b0;
      held_ticks[k]   = '0;
      repeat_ticks[k] = '0;
    end
    for (int i = 0; i < FIFO_SLOTS; i++)
      code_slots[i] = '0;
    wr_ptr = '0;
    rd_ptr = '0;
    cfg_shadow = '{long_press_ticks: LONG_PRESS_RST, repeat_period: RPT_PERIOD_RST,
                   long_enable_mask: LONG_MASK_RST, repeat_enable_mask: RPT_MASK_RST};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset settings
    for (int i = 0; i < N_ROWS; i++)
      send_item(directed_rows[i].mode, directed_rows[i].pins,
                directed_rows[i].fixed, directed_rows[i].want);
    run_phase(PHASE_ITEMS, 0);

    // fastest repeat on every key
    apply_settings(16'd1, 8'd1, 8'hFF, 8'hFF);
    run_phase(PHASE_ITEMS, 0);

    // long press and repeat off
    apply_settings(16'd0, 8'd0, 8'h00, 8'h00);
    run_phase(PHASE_ITEMS, 0);

    // longest threshold, slowest repeat period, repeat masked off on every key
    apply_settings(16'hFFFF, 8'hFF, 8'hFF, 8'h00);
    run_phase(PHASE_ITEMS, 0);

    // short threshold with the slowest repeat, one hold long enough to reach it
    apply_settings(16'($urandom_range(2, 12)), 8'hFF, 8'hFF, 8'hFF);
    run_phase(PHASE_ITEMS, 280);

    // random settings, with the response side held off to back the unit up
    apply_settings(16'($urandom_range(1, 8)), 8'($urandom_range(2, 5)),
                   8'($urandom()), 8'($urandom()));
    squeeze_req = 1'b1;
    run_phase(PHASE_ITEMS, 0);

    // closing stretch with no idling on either side
    apply_settings(16'd2, 8'd1, 8'($urandom()), 8'($urandom()));
    idle_on = 1'b0;
    run_phase(PHASE_ITEMS, 0);

    wait_idle();
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- key_debounce_repeat_fifo_unit.f -----
rtl/core/kdr_pkg.sv
rtl/core/kdr_channels.sv
rtl/core/kdr_regs.sv
rtl/core/kdr_ctrl.sv
rtl/core/kdr_datapath.sv
rtl/core/key_debounce_repeat_fifo_unit.sv
rtl/core/kdr_checker.sv
bench/tb_key_debounce_repeat_fifo_unit.sv
